### sv/osds_pkg.sv
// Package for the OBEX service descriptor scanner.
// Holds the transaction payload types, register indexes, status codes and
// descriptor layout constants. Depends on nothing.
package osds_pkg;

  localparam int UUID_BYTES         = 16;
  localparam int MIN_SERVICE_LENGTH = 22;

  // Byte offsets inside the service identifier descriptor.
  localparam int OFF_ROLE   = 3;
  localparam int OFF_UUID   = 4;
  localparam int OFF_VER_HI = OFF_UUID + UUID_BYTES;
  localparam int OFF_VER_LO = OFF_VER_HI + 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CS_INTERFACE_TYPE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_ID_SUBTYPE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_UUID_UPPER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_UUID_LOWER = CFG_IDX_W'(3);

  localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  scan_status;
    logic [7:0]  service_role;
    logic [63:0] uuid_upper;
    logic [63:0] uuid_lower;
    logic [15:0] service_version;
    logic        uuid_is_default;
  } out_item_t;

endpackage

### sv/obex_service_descriptor_scanner.sv
// Top level of the OBEX service descriptor scanner.
// Walks a descriptor buffer byte by byte and reports the service identifier.
// Depends on osds_pkg.
//
// Usage:
//   The input channel carries one buffer byte per transaction together with
//   an end-of-buffer mark. The block walks the length-prefixed descriptors
//   and keeps the role, UUID and version of the first complete service
//   identifier descriptor. A transaction with the end mark yields exactly one
//   result on the output channel: not found, found or malformed; others
//   yield none. The scan state then returns to its reset condition.
//   One byte is accepted every cycle while no end-marked byte is stalled. The result
//   appears in the output register in the cycle after its final byte is
//   accepted. All per-byte work is a counter compare and a byte compare
//   between the state registers and the result register.
//   If the receiver stalls a waiting result, bytes without the end mark are
//   still accepted; only a byte carrying the end mark is stalled until the
//   result has been taken.
//   The configuration channel is always ready; writes are meant for idle
//   periods. Reset restores the default register values and clears the scan.
module obex_service_descriptor_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  osds_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output osds_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [osds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [osds_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import osds_pkg::*;

  // Configuration registers.
  logic [7:0]   cs_type_q;
  logic [7:0]   subtype_q;
  logic [127:0] dflt_uuid_q;

  // Scan state.
  logic [7:0]   off_q, off_d;
  logic [7:0]   len_q, len_d;
  logic         cand_q, cand_d;
  logic         found_q, found_d;
  logic         mal_q, mal_d;
  logic         match_q, match_d;
  logic [7:0]   role_q, role_d;
  logic [127:0] uuid_q, uuid_d;
  logic [15:0]  ver_q, ver_d;

  logic         out_valid_q;
  out_item_t    out_q, res;

  logic         in_acc;
  logic         res_load;
  logic [7:0]   b;
  logic [3:0]   uuid_idx;
  logic [7:0]   dflt_byte;
  logic [8:0]   nxt;
  logic         cand_sel;

  assign cfg_ready_o = 1'b1;

  // A byte with the end mark needs the result register free.
  assign in_stall_o = out_valid_q & out_stall_i & in_data_i.end_of_buffer;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign res_load   = in_acc & in_data_i.end_of_buffer;

  assign b         = in_data_i.data_byte;
  assign uuid_idx  = 4'(off_q - 8'(OFF_UUID));
  assign dflt_byte = dflt_uuid_q[{~uuid_idx, 3'b000} +: 8];
  assign cand_sel  = cand_q && (b == subtype_q) &&
                     (len_q >= 8'(MIN_SERVICE_LENGTH)) && !found_q;

  always_comb begin
    off_d   = off_q;
    len_d   = len_q;
    cand_d  = cand_q;
    found_d = found_q;
    mal_d   = mal_q;
    match_d = match_q;
    role_d  = role_q;
    uuid_d  = uuid_q;
    ver_d   = ver_q;
    nxt     = {1'b0, off_q} + 9'd1;
    if (!mal_q) begin
      if (off_q == 8'd0) begin
        len_d  = b;
        cand_d = 1'b0;
        if (b == 8'd0) begin
          mal_d = 1'b1;
        end
      end else if (off_q == 8'd1) begin
        cand_d = (b == cs_type_q);
      end else if (off_q == 8'd2) begin
        cand_d = cand_sel;
        if (cand_sel) begin
          match_d = 1'b1;
        end
      end else if (cand_q) begin
        if (off_q == 8'(OFF_ROLE)) begin
          role_d = b;
        end else if (off_q >= 8'(OFF_UUID) && off_q < 8'(OFF_VER_HI)) begin
          for (int i = 0; i < UUID_BYTES; i++) begin
            if (uuid_idx == 4'(i)) begin
              uuid_d[8*(UUID_BYTES-1-i) +: 8] = b;
            end
          end
          if (b != dflt_byte) begin
            match_d = 1'b0;
          end
        end else if (off_q == 8'(OFF_VER_HI)) begin
          ver_d = {b, 8'h00};
        end else if (off_q == 8'(OFF_VER_LO)) begin
          ver_d   = {ver_q[15:8], b};
          found_d = 1'b1;
          cand_d  = 1'b0;
        end
      end
      if (!mal_d) begin
        off_d = (nxt >= {1'b0, len_d}) ? 8'd0 : nxt[7:0];
      end
    end
  end

  always_comb begin
    res = '0;
    if (mal_d) begin
      res.scan_status = STATUS_MALFORMED;
    end else if (found_d) begin
      res.scan_status     = STATUS_FOUND;
      res.service_role    = role_d;
      res.uuid_upper      = uuid_d[127:64];
      res.uuid_lower      = uuid_d[63:0];
      res.service_version = ver_d;
      res.uuid_is_default = match_d;
    end else begin
      res.scan_status = STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_type_q   <= 8'd36;
      subtype_q   <= 8'd25;
      dflt_uuid_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CS_INTERFACE_TYPE:  cs_type_q <= cfg_data_i[7:0];
        REG_SERVICE_ID_SUBTYPE: subtype_q <= cfg_data_i[7:0];
        REG_DEFAULT_UUID_UPPER: dflt_uuid_q[127:64] <= cfg_data_i;
        REG_DEFAULT_UUID_LOWER: dflt_uuid_q[63:0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state; the stored descriptor bytes are only read once found.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      len_q   <= '0;
      cand_q  <= 1'b0;
      found_q <= 1'b0;
      mal_q   <= 1'b0;
      match_q <= 1'b1;
    end else if (res_load) begin
      off_q   <= '0;
      len_q   <= '0;
      cand_q  <= 1'b0;
      found_q <= 1'b0;
      mal_q   <= 1'b0;
      match_q <= 1'b1;
    end else if (in_acc) begin
      off_q   <= off_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
      found_q <= found_d;
      mal_q   <= mal_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      role_q <= role_d;
      uuid_q <= uuid_d;
      ver_q  <= ver_d;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_off_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_q != 8'd0) |-> (off_q < len_q))
    else $error("descriptor offset not below descriptor length");

  a_mal_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mal_q |-> (off_q == 8'd0))
    else $error("offset moved after a zero-length descriptor");

  a_res_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res_load))
    else $error("result appeared without a final byte");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.scan_status == STATUS_NOT_FOUND ||
                     out_q.scan_status == STATUS_FOUND ||
                     out_q.scan_status == STATUS_MALFORMED))
    else $error("undefined scan status in result register");

endmodule
